FILE: rtl/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, codes and helpers for the deadlock-avoiding resource allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int RES               = 3;
   localparam int UNIT_W            = 8;
   localparam int CUSTOMERS_DEFAULT = 8;
   localparam int CSR_COUNT         = 3;
   localparam int CSR_INDEX_W       = 2;

   localparam logic [1:0] FUNC_REQUEST = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_CLAIM   = 2'd2;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_NEED    = 3'd1;
   localparam logic [2:0] ST_AVAIL   = 3'd2;
   localparam logic [2:0] ST_UNSAFE  = 3'd3;
   localparam logic [2:0] ST_RELEASE = 3'd4;
   localparam logic [2:0] ST_CLAIM   = 3'd5;

   typedef logic [RES-1:0][UNIT_W-1:0] units_type;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] customer;
      logic [7:0] amount_0;
      logic [7:0] amount_1;
      logic [7:0] amount_2;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] free_0;
      logic [7:0] free_1;
      logic [7:0] free_2;
   } rsp_type;

   function automatic logic [UNIT_W-1:0] sat_add8(input logic [UNIT_W-1:0] a,
                                                  input logic [UNIT_W-1:0] b);
      logic [UNIT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[UNIT_W] ? {UNIT_W{1'b1}} : s[UNIT_W-1:0];
   endfunction

endpackage

FILE: rtl/bra_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_scan_unit
// Shared fit-and-accumulate step of the safety scan: one customer per use.
// ----------------------------------------------------------------------------
module bra_scan_unit
   import bra_pkg::*;
#(
   parameter int WORK_W = 12
) (
   input  logic [RES-1:0][WORK_W-1:0] work,
   input  units_type                  need,
   input  units_type                  held,
   input  logic                       finished,
   output logic                       take,
   output logic [RES-1:0][WORK_W-1:0] work_sum
);

   logic fits;

   always_comb begin
      fits = 1'b1;
      for (int r = 0; r < RES; r++) begin
         if (WORK_W'(need[r]) > work[r]) begin
            fits = 1'b0;
         end
         work_sum[r] = work[r] + WORK_W'(held[r]);
      end
      take = fits && !finished;
   end

endmodule

FILE: rtl/bankers_resource_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_resource_allocator_unit
// Banker's algorithm allocator for three resource types: request, release and
// claim load per customer, with an iterative safety scan over all customers.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_item          taken when start and not busy
//  result    rsp_strobe, rsp_item           one-cycle strobe, no back pressure
//  config    csr_we, csr_index, csr_data    written on csr_we, index < 3
//
//  release, claim, rejected request: S_CHECK, then S_RESP, then the strobe
//  request that reaches the scan: S_CHECK, S_INIT, P passes of S_SCAN,
//  S_ROLLBACK if unsafe, S_RESP; P = number of scan passes (1 .. CUSTOMERS);
//  one customer row per cycle through the shared fit/accumulate unit
//  busy is high from accept until the result strobe; a new item may be
//  started in the strobe cycle
//  synchronous reset clears totals, available counts, needs and holdings
// ----------------------------------------------------------------------------
module bankers_resource_allocator_unit
   import bra_pkg::*;
#(
   parameter int CUSTOMERS = CUSTOMERS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [UNIT_W-1:0]      csr_data
);

   localparam int IDX_W  = $clog2(CUSTOMERS);
   localparam int WORK_W = UNIT_W + $clog2(CUSTOMERS + 1);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(CUSTOMERS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_INIT,
      S_SCAN,
      S_ROLLBACK,
      S_RESP
   } state_type;

   state_type                  state_ff, state_in;
   req_type                    req_ff, req_in;
   logic                       in_range_ff, in_range_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]           pass_ff, pass_in;
   logic                       progress_ff, progress_in;
   logic [CUSTOMERS-1:0]       fin_ff, fin_in;
   logic [RES-1:0][WORK_W-1:0] work_ff, work_in;
   logic [2:0]                 status_ff, status_in;
   units_type                  total_ff, total_in;
   units_type                  avail_ff, avail_in;
   units_type                  need_ff [CUSTOMERS];
   units_type                  held_ff [CUSTOMERS];
   logic                       rsp_strobe_ff, rsp_strobe_in;
   rsp_type                    rsp_item_ff, rsp_item_in;

   units_type                  row_need, row_held;
   units_type                  row_need_in, row_held_in;
   logic                       row_we;
   units_type                  amt;
   logic                       any_amt;
   logic                       over_need, over_avail, over_held, over_total;
   logic                       take;
   logic [RES-1:0][WORK_W-1:0] work_sum;

   assign row_need = need_ff[idx_ff];
   assign row_held = held_ff[idx_ff];
   assign amt      = {req_ff.amount_2, req_ff.amount_1, req_ff.amount_0};
   assign any_amt  = |amt;

   bra_scan_unit #(
      .WORK_W (WORK_W)
   ) u_scan (
      .work     (work_ff),
      .need     (row_need),
      .held     (row_held),
      .finished (fin_ff[idx_ff]),
      .take     (take),
      .work_sum (work_sum)
   );

   always_comb begin
      over_need  = 1'b0;
      over_avail = 1'b0;
      over_held  = 1'b0;
      over_total = 1'b0;
      for (int r = 0; r < RES; r++) begin
         if (amt[r] > row_need[r])  over_need  = 1'b1;
         if (amt[r] > avail_ff[r])  over_avail = 1'b1;
         if (amt[r] > row_held[r])  over_held  = 1'b1;
         if (amt[r] > total_ff[r])  over_total = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      in_range_in   = in_range_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      progress_in   = progress_ff;
      fin_in        = fin_ff;
      work_in       = work_ff;
      status_in     = status_ff;
      total_in      = total_ff;
      avail_in      = avail_ff;
      row_need_in   = row_need;
      row_held_in   = row_held;
      row_we        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;

      if (csr_we && (csr_index < CSR_INDEX_W'(CSR_COUNT))) begin
         total_in[csr_index] = csr_data;
         avail_in[csr_index] = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_item;
               in_range_in = ({3'b000, req_item.customer} < 6'(CUSTOMERS));
               idx_in      = IDX_W'(req_item.customer);
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = ST_DONE;
            state_in  = S_RESP;
            if (!in_range_ff) begin
               if (req_ff.func == FUNC_REQUEST && any_amt) begin
                  status_in = ST_NEED;
               end else if (req_ff.func == FUNC_RELEASE && any_amt) begin
                  status_in = ST_RELEASE;
               end
            end else begin
               case (req_ff.func)
                  FUNC_REQUEST: begin
                     if (over_need) begin
                        status_in = ST_NEED;
                     end else if (over_avail) begin
                        status_in = ST_AVAIL;
                     end else begin
                        row_we = 1'b1;
                        for (int r = 0; r < RES; r++) begin
                           avail_in[r]    = avail_ff[r] - amt[r];
                           row_need_in[r] = row_need[r] - amt[r];
                           row_held_in[r] = row_held[r] + amt[r];
                        end
                        state_in = S_INIT;
                     end
                  end
                  FUNC_RELEASE: begin
                     if (over_held) begin
                        status_in = ST_RELEASE;
                     end else begin
                        row_we = 1'b1;
                        for (int r = 0; r < RES; r++) begin
                           row_held_in[r] = row_held[r] - amt[r];
                           avail_in[r]    = sat_add8(avail_ff[r], amt[r]);
                           row_need_in[r] = sat_add8(row_need[r], amt[r]);
                        end
                     end
                  end
                  FUNC_CLAIM: begin
                     if (over_total) begin
                        status_in = ST_CLAIM;
                     end else begin
                        row_we = 1'b1;
                        for (int r = 0; r < RES; r++) begin
                           avail_in[r]    = sat_add8(avail_ff[r], row_held[r]);
                           row_held_in[r] = '0;
                           row_need_in[r] = amt[r];
                        end
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_INIT: begin
            for (int r = 0; r < RES; r++) begin
               work_in[r] = WORK_W'(avail_ff[r]);
            end
            fin_in      = '0;
            idx_in      = '0;
            pass_in     = '0;
            progress_in = 1'b0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (take) begin
               work_in        = work_sum;
               fin_in[idx_ff] = 1'b1;
               progress_in    = 1'b1;
            end
            if (idx_ff == LAST) begin
               if (&fin_in) begin
                  status_in = ST_DONE;
                  state_in  = S_RESP;
               end else if (!progress_in || pass_ff == LAST) begin
                  idx_in   = IDX_W'(req_ff.customer);
                  state_in = S_ROLLBACK;
               end else begin
                  pass_in     = pass_ff + 1'b1;
                  idx_in      = '0;
                  progress_in = 1'b0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ROLLBACK: begin
            row_we = 1'b1;
            for (int r = 0; r < RES; r++) begin
               avail_in[r]    = avail_ff[r] + amt[r];
               row_need_in[r] = row_need[r] + amt[r];
               row_held_in[r] = row_held[r] - amt[r];
            end
            status_in = ST_UNSAFE;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_strobe_in      = 1'b1;
            rsp_item_in.status = status_ff;
            rsp_item_in.free_0 = avail_ff[0];
            rsp_item_in.free_1 = avail_ff[1];
            rsp_item_in.free_2 = avail_ff[2];
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= '0;
         avail_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int c = 0; c < CUSTOMERS; c++) begin
            need_ff[c] <= '0;
            held_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         avail_ff      <= avail_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (row_we) begin
            need_ff[idx_ff] <= row_need_in;
            held_ff[idx_ff] <= row_held_in;
         end
      end
      req_ff      <= req_in;
      in_range_ff <= in_range_in;
      idx_ff      <= idx_in;
      pass_ff     <= pass_in;
      progress_ff <= progress_in;
      fin_ff      <= fin_in;
      work_ff     <= work_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_unsafe_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_UNSAFE) |-> (req_ff.func == FUNC_REQUEST))
      else $error("unsafe status on an item that is not a request");

   a_scan_in_request: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (in_range_ff && req_ff.func == FUNC_REQUEST))
      else $error("safety scan running for an item that is not a request");

endmodule
